// ===== rtl/holiday_calendar_engine_core_assert.svh =====
// Assertion macros used by the holiday calendar engine RTL.
`ifndef HOLIDAY_CALENDAR_ENGINE_CORE_ASSERT_SVH
`define HOLIDAY_CALENDAR_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HCE_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HCE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hce_pkg.sv =====
// Shared types, constants, holiday table and helper functions of the holiday engine.
`default_nettype none

package hce_pkg;

  localparam int NUM_HOLIDAYS_DEF = 29;
  localparam int TABLE_LEN        = 29;
  localparam int CFG_IDX_W        = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_MASK = 1'b0,
    REG_USE_SUMMER  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_FIXED  = 2'd0,
    KIND_EASTER = 2'd1,
    KIND_ADVENT = 2'd2
  } hol_kind_t;

  typedef struct packed {
    hol_kind_t   kind;
    logic [7:0]  ofs;   // day of month, or signed day offset
    logic [3:0]  mon;   // month of a fixed date
  } hol_entry_t;

  // Input item as carried on s_tdata, lowest field in the lowest bits.
  typedef struct packed {
    logic [5:0]  pad;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } in_item_t;

  // Result item as carried on m_tdata, lowest field in the lowest bits.
  typedef struct packed {
    logic [6:0] pad;
    logic [4:0] advent_day;
    logic [4:0] easter_day;
    logic [2:0] easter_month;
    logic       is_summertime;
    logic       holiday_changed;
    logic [4:0] holiday_tomorrow;
    logic [4:0] holiday_today;
  } out_item_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
  } date_t;

  typedef struct packed {
    logic [2:0] easter_month;
    logic [4:0] easter_day;
    logic [4:0] advent_day;
    logic       summer;
    logic [8:0] east_ord;
    logic [8:0] adv_ord;
    logic [8:0] today_ord;
    logic [8:0] tomorrow_ord;
    logic       leap;
    logic       month_ok;
  } calc_res_t;

  typedef struct packed {
    logic [8:0] east_ord;
    logic [8:0] adv_ord;
    logic [8:0] today_ord;
    logic [8:0] tomorrow_ord;
    logic       leap;
  } scan_in_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [4:0] today;
    logic [4:0] tomorrow;
  } scan_out_t;

  function automatic hol_entry_t mk_entry(input hol_kind_t kind, input int ofs,
                                          input int mon);
    hol_entry_t ent;
    ent.kind = kind;
    ent.ofs  = 8'(ofs);
    ent.mon  = 4'(mon);
    return ent;
  endfunction

  function automatic hol_entry_t hol_entry(input logic [4:0] idx);
    hol_entry_t ent;
    unique case (idx)
      5'd0:    ent = mk_entry(KIND_FIXED, 1, 1);
      5'd1:    ent = mk_entry(KIND_FIXED, 6, 1);
      5'd2:    ent = mk_entry(KIND_EASTER, -52, 0);
      5'd3:    ent = mk_entry(KIND_EASTER, -48, 0);
      5'd4:    ent = mk_entry(KIND_EASTER, -47, 0);
      5'd5:    ent = mk_entry(KIND_EASTER, -46, 0);
      5'd6:    ent = mk_entry(KIND_EASTER, -3, 0);
      5'd7:    ent = mk_entry(KIND_EASTER, -2, 0);
      5'd8:    ent = mk_entry(KIND_EASTER, 0, 0);
      5'd9:    ent = mk_entry(KIND_EASTER, 1, 0);
      5'd10:   ent = mk_entry(KIND_FIXED, 1, 5);
      5'd11:   ent = mk_entry(KIND_EASTER, 39, 0);
      5'd12:   ent = mk_entry(KIND_EASTER, 49, 0);
      5'd13:   ent = mk_entry(KIND_EASTER, 50, 0);
      5'd14:   ent = mk_entry(KIND_EASTER, 60, 0);
      5'd15:   ent = mk_entry(KIND_FIXED, 8, 8);
      5'd16:   ent = mk_entry(KIND_FIXED, 15, 8);
      5'd17:   ent = mk_entry(KIND_FIXED, 3, 10);
      5'd18:   ent = mk_entry(KIND_FIXED, 31, 10);
      5'd19:   ent = mk_entry(KIND_FIXED, 1, 11);
      5'd20:   ent = mk_entry(KIND_ADVENT, -32, 0);
      5'd21:   ent = mk_entry(KIND_ADVENT, -21, 0);
      5'd22:   ent = mk_entry(KIND_ADVENT, -14, 0);
      5'd23:   ent = mk_entry(KIND_ADVENT, -7, 0);
      5'd24:   ent = mk_entry(KIND_ADVENT, 0, 0);
      5'd25:   ent = mk_entry(KIND_FIXED, 24, 12);
      5'd26:   ent = mk_entry(KIND_FIXED, 25, 12);
      5'd27:   ent = mk_entry(KIND_FIXED, 26, 12);
      5'd28:   ent = mk_entry(KIND_FIXED, 31, 12);
      default: ent = mk_entry(KIND_FIXED, 0, 0);
    endcase
    return ent;
  endfunction

  // Days in the year before the first of the month (non-leap).
  function automatic logic [8:0] days_before(input logic [3:0] mon);
    logic [8:0] res;
    unique case (mon)
      4'd1:    res = 9'd0;
      4'd2:    res = 9'd31;
      4'd3:    res = 9'd59;
      4'd4:    res = 9'd90;
      4'd5:    res = 9'd120;
      4'd6:    res = 9'd151;
      4'd7:    res = 9'd181;
      4'd8:    res = 9'd212;
      4'd9:    res = 9'd243;
      4'd10:   res = 9'd273;
      4'd11:   res = 9'd304;
      4'd12:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // x mod 7 by reciprocal multiply; exact for any 13-bit x.
  function automatic logic [2:0] mod7(input logic [12:0] x);
    logic [26:0] prod;
    logic [10:0] quo;
    logic [13:0] rem;
    prod = 27'(x) * 27'd9363;
    quo  = prod[26:16];
    rem  = 14'(x) - ({quo, 3'b000} - 14'(quo));
    return rem[2:0];
  endfunction

  // x mod 30 by reciprocal multiply; exact for any 9-bit x.
  function automatic logic [4:0] mod30(input logic [8:0] x);
    logic [19:0] prod;
    logic [4:0]  quo;
    logic [9:0]  rem;
    prod = 20'(x) * 20'd1093;
    quo  = prod[19:15];
    rem  = 10'(x) - ({quo, 5'b00000} - {4'b0000, quo, 1'b0});
    return rem[4:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hce_calc.sv =====
// Date arithmetic sequencer: Gauss Easter, fourth Advent, summertime and day ordinals.
`default_nettype none

module hce_calc (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hce_pkg::date_t    date,
  input  logic              use_summer,
  output hce_pkg::calc_res_t res,
  output logic              done
);

  typedef enum logic [7:0] {
    C_IDLE   = 8'b0000_0001,
    C_DIV    = 8'b0000_0010,
    C_REM    = 8'b0000_0100,
    C_GAUSS  = 8'b0000_1000,
    C_DMOD   = 8'b0001_0000,
    C_EMOD   = 8'b0010_0000,
    C_EASTER = 8'b0100_0000,
    C_ORD    = 8'b1000_0000
  } calc_state_t;

  calc_state_t state, state_next;

  hce_pkg::date_t dt;
  logic [7:0]  q19;
  logic [5:0]  cent;
  logic [9:0]  q7;
  logic [4:0]  ga;
  logic [2:0]  gc;
  logic [4:0]  gp;
  logic        leap;
  logic [12:0] wbase;
  logic [4:0]  mm;
  logic [2:0]  nn;
  logic [4:0]  adv;
  logic [4:0]  ls3;
  logic [4:0]  ls10;
  logic [4:0]  gd;
  logic        summer;
  logic [8:0]  adv_ord;
  logic [2:0]  ge;
  logic [2:0]  em;
  logic [4:0]  ed;

  // divide step
  logic [23:0] prod19;
  logic [24:0] prod100;
  logic [25:0] prod7;
  // remainder step
  logic [11:0] rem19;
  logic [12:0] rem7;
  logic [11:0] hund;
  logic        leap_c;
  logic [8:0]  pnum;
  logic [14:0] pprod;
  logic [12:0] wbase_c;
  // Gauss step
  logic [5:0]  s_c;
  logic [5:0]  egz_c;
  logic [5:0]  t_c;
  logic [4:0]  mm_c;
  logic [2:0]  nn_c;
  logic [2:0]  wd12;
  logic [2:0]  wd3;
  logic [2:0]  wd10;
  // day-of-moon and summertime step
  logic [8:0]  x_c;
  logic        summer_c;
  // weekday correction step
  logic [12:0] esum;
  // Easter date step
  logic [5:0]  sum_c;
  logic [5:0]  ed_alt6;
  logic [4:0]  ed_alt;
  logic [2:0]  em_c;
  logic [4:0]  ed_c;
  // ordinal step
  logic [9:0]  tod_raw;
  logic [9:0]  year_len;
  logic [9:0]  tod_c;
  logic [8:0]  tom_c;
  logic [8:0]  east_c;

  always_comb begin
    prod19  = 24'(dt.year) * 24'd3450;
    prod100 = 25'(dt.year) * 25'd5243;
    prod7   = 26'(dt.year) * 26'd9363;
  end

  always_comb begin
    rem19   = dt.year - ({q19, 4'b0000} + {3'b000, q19, 1'b0} + {4'b0000, q19});
    rem7    = 13'(dt.year) - ({q7, 3'b000} - 13'(q7));
    hund    = {cent, 6'b0} + {1'b0, cent, 5'b0} + {4'b0000, cent, 2'b00};
    leap_c  = (dt.year[1:0] == 2'b00) && ((dt.year != hund) || (cent[1:0] == 2'b00));
    pnum    = {cent, 3'b000} + 9'd13;
    pprod   = 15'(pnum) * 15'd41;
    wbase_c = 13'(dt.year) + 13'(dt.year[11:2]) - 13'(cent) + 13'(cent[5:2]);
  end

  always_comb begin
    s_c   = 6'd38 + 6'(gp) - cent + 6'(cent[5:2]);
    egz_c = (s_c >= 6'd30) ? s_c - 6'd30 : s_c;
    t_c   = 6'd53 - egz_c;
    mm_c  = (t_c >= 6'd30) ? 5'(t_c - 6'd30) : 5'(t_c);
    nn_c  = hce_pkg::mod7(13'(6'd4 + cent - 6'(cent[5:2])));
    // weekdays of Dec 24, Mar 31 and Oct 31, Sunday = 0
    wd12  = hce_pkg::mod7(wbase + 13'd28);
    wd3   = hce_pkg::mod7(wbase + 13'd33);
    wd10  = hce_pkg::mod7(wbase + 13'd37);
  end

  always_comb begin
    x_c = {ga, 4'b0000} + {3'b000, ga, 1'b0} + {4'b0000, ga} + {4'b0000, mm};
    summer_c = 1'b0;
    if (use_summer) begin
      priority if (dt.month == 4'd3) begin
        summer_c = (ls3 == dt.day) ? (dt.hour > 5'd3) : (ls3 < dt.day);
      end else if (dt.month == 4'd10) begin
        summer_c = (ls10 == dt.day) ? (dt.hour < 5'd3) : (ls10 > dt.day);
      end else begin
        summer_c = (dt.month > 4'd3) && (dt.month < 4'd10);
      end
    end
  end

  always_comb begin
    esum = 13'({dt.year[1:0], 1'b0}) + 13'({gc, 2'b00}) + 13'({gd, 2'b00})
         + 13'({gd, 1'b0}) + 13'(nn);
  end

  always_comb begin
    sum_c   = 6'd22 + 6'(gd) + 6'(ge);
    ed_alt6 = 6'(gd) + 6'(ge) - 6'd9;
    ed_alt  = ed_alt6[4:0];
    if (sum_c <= 6'd31) begin
      em_c = 3'd3;
      ed_c = sum_c[4:0];
    end else begin
      em_c = 3'd4;
      priority if (ed_alt == 5'd26) begin
        ed_c = 5'd19;
      end else if ((ed_alt == 5'd25) && (gd == 5'd28) && (ga > 5'd10)) begin
        ed_c = 5'd18;
      end else begin
        ed_c = ed_alt;
      end
    end
  end

  always_comb begin
    east_c   = hce_pkg::days_before(4'(em)) + 9'(ed) + 9'(leap);
    tod_raw  = 10'(hce_pkg::days_before(dt.month)) + 10'(dt.day)
             + 10'(leap && (dt.month > 4'd2));
    year_len = 10'd365 + 10'(leap);
    // day 0 wraps to the end of the year, past the end wraps to the start
    priority if (tod_raw == 10'd0) begin
      tod_c = year_len;
    end else if (tod_raw > year_len) begin
      tod_c = tod_raw - year_len;
    end else begin
      tod_c = tod_raw;
    end
    tom_c = (tod_c == year_len) ? 9'd1 : 9'(tod_c + 10'd1);
  end

  always_comb begin
    unique case (state)
      C_IDLE:   state_next = start ? C_DIV : C_IDLE;
      C_DIV:    state_next = C_REM;
      C_REM:    state_next = C_GAUSS;
      C_GAUSS:  state_next = C_DMOD;
      C_DMOD:   state_next = C_EMOD;
      C_EMOD:   state_next = C_EASTER;
      C_EASTER: state_next = C_ORD;
      C_ORD:    state_next = C_IDLE;
      default:  state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == C_ORD);
    end
  end

  always_ff @(posedge clk) begin
    if (state == C_IDLE && start) begin
      dt <= date;
    end
    if (state == C_DIV) begin
      q19  <= prod19[23:16];
      cent <= prod100[24:19];
      q7   <= prod7[25:16];
    end
    if (state == C_REM) begin
      ga    <= rem19[4:0];
      gc    <= rem7[2:0];
      gp    <= pprod[14:10];
      leap  <= leap_c;
      wbase <= wbase_c;
    end
    if (state == C_GAUSS) begin
      mm   <= mm_c;
      nn   <= nn_c;
      adv  <= 5'd24 - 5'(wd12);
      ls3  <= 5'd31 - 5'(wd3);
      ls10 <= 5'd31 - 5'(wd10);
    end
    if (state == C_DMOD) begin
      gd      <= hce_pkg::mod30(x_c);
      summer  <= summer_c;
      adv_ord <= 9'd334 + 9'(adv) + 9'(leap);
    end
    if (state == C_EMOD) begin
      ge <= hce_pkg::mod7(esum);
    end
    if (state == C_EASTER) begin
      em <= em_c;
      ed <= ed_c;
    end
    if (state == C_ORD) begin
      res.easter_month <= em;
      res.easter_day   <= ed;
      res.advent_day   <= adv;
      res.summer       <= summer;
      res.east_ord     <= east_c;
      res.adv_ord      <= adv_ord;
      res.today_ord    <= tod_c[8:0];
      res.tomorrow_ord <= tom_c;
      res.leap         <= leap;
      res.month_ok     <= (dt.month != 4'd0) && (dt.month <= 4'd12);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hce_scan.sv =====
// Holiday table scan: one entry per cycle through a shared add and compare unit.
`default_nettype none

module hce_scan #(
  parameter int NUM_HOLIDAYS = hce_pkg::NUM_HOLIDAYS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  hce_pkg::scan_in_t   scan_in,
  input  logic [31:0]         enable_mask,
  output hce_pkg::scan_out_t  scan_out
);

  localparam int IDX_W = (NUM_HOLIDAYS > 1) ? $clog2(NUM_HOLIDAYS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_HOLIDAYS - 1);

  logic             busy;
  logic             done;
  logic [IDX_W-1:0] idx;
  logic [4:0]       nt;
  logic [4:0]       nm;

  hce_pkg::hol_entry_t ent;
  logic [4:0]        idx5;
  logic              live;
  logic [8:0]        base;
  logic signed [9:0] hday;
  logic              hit_t;
  logic              hit_m;
  logic [4:0]        nt_next;
  logic [4:0]        nm_next;
  logic              finish;

  always_comb begin
    idx5 = 5'(idx);
    ent  = hce_pkg::hol_entry(idx5);
    live = (idx5 < 5'(hce_pkg::TABLE_LEN)) && enable_mask[5'd31 - idx5];
    unique case (ent.kind)
      hce_pkg::KIND_EASTER: base = scan_in.east_ord;
      hce_pkg::KIND_ADVENT: base = scan_in.adv_ord;
      hce_pkg::KIND_FIXED:  base = hce_pkg::days_before(ent.mon)
                                 + 9'(scan_in.leap && (ent.mon > 4'd2));
      default:              base = 9'd0;
    endcase
    hday    = $signed({1'b0, base}) + 10'(signed'(ent.ofs));
    hit_t   = live && (hday == $signed({1'b0, scan_in.today_ord}));
    hit_m   = live && (hday == $signed({1'b0, scan_in.tomorrow_ord}));
    nt_next = hit_t ? idx5 + 5'd1 : nt;
    nm_next = hit_m ? idx5 + 5'd1 : nm;
    // stop at the table end or as soon as both days have a holiday
    finish  = (idx == LAST_IDX) || ((nt_next != 5'd0) && (nm_next != 5'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && finish) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx <= '0;
      nt  <= 5'd0;
      nm  <= 5'd0;
    end else if (busy) begin
      nt <= nt_next;
      nm <= nm_next;
      if (!finish) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  assign scan_out.busy     = busy;
  assign scan_out.done     = done;
  assign scan_out.today    = nt;
  assign scan_out.tomorrow = nm;

endmodule

`default_nettype wire

// ===== rtl/holiday_calendar_engine_core.sv =====
// Top level of the holiday calendar engine: handshakes, sequencer, state and config.
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid/s_tready    s_tdata date, s_tuser date_valid
//   m_       out  m_tvalid/m_tready    m_tdata holiday results, Easter, Advent
//   cfg_     in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// A transaction is taken in idle, then the calc sequencer runs its 7 steps and signals
// done. For a valid date in a real month the scan unit then checks one table entry per
// cycle, stopping early once both days have a match; the output register is loaded
// after that, once m_tready has taken any earlier result. s_tready is high only in idle;
// a stalled m_tready holds the result and the next item's completion. Reset clears
// control state.
`default_nettype none

module holiday_calendar_engine_core #(
  parameter int NUM_HOLIDAYS = hce_pkg::NUM_HOLIDAYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [11:0] year, [15:12] month, [20:16] day, [25:21] hour, [31:26] zero
  input  logic [31:0]                   s_tdata,
  // [0] date_valid
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [4:0] holiday_today, [9:5] holiday_tomorrow, [10] holiday_changed,
  // [11] is_summertime, [14:12] easter_month, [19:15] easter_day,
  // [24:20] advent_day, [31:25] zero
  output logic [31:0]                   m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  `include "holiday_calendar_engine_core_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [31:0]         enable_mask;
  logic                use_summer;
  logic                item_valid;
  logic [4:0]          res_today;
  logic [4:0]          res_tomorrow;
  logic [4:0]          stored_today;
  logic [4:0]          stored_tomorrow;
  hce_pkg::out_item_t  out_q;

  hce_pkg::in_item_t   in_item;
  hce_pkg::date_t      date;
  hce_pkg::calc_res_t  calc_res;
  logic                calc_done;
  hce_pkg::scan_in_t   scan_in;
  hce_pkg::scan_out_t  scan_out;
  logic                in_accept;
  logic                scan_start;
  logic                out_load;
  hce_pkg::out_item_t  out_next;

  assign in_item   = hce_pkg::in_item_t'(s_tdata);
  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    date.year  = in_item.year;
    date.month = in_item.month;
    date.day   = in_item.day;
    date.hour  = in_item.hour;
  end

  hce_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .start      (in_accept),
    .date       (date),
    .use_summer (use_summer),
    .res        (calc_res),
    .done       (calc_done)
  );

  always_comb begin
    scan_in.east_ord     = calc_res.east_ord;
    scan_in.adv_ord      = calc_res.adv_ord;
    scan_in.today_ord    = calc_res.today_ord;
    scan_in.tomorrow_ord = calc_res.tomorrow_ord;
    scan_in.leap         = calc_res.leap;
  end

  hce_scan #(
    .NUM_HOLIDAYS (NUM_HOLIDAYS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .scan_in     (scan_in),
    .enable_mask (enable_mask),
    .scan_out    (scan_out)
  );

  assign scan_start = (state == S_CALC) && calc_done && item_valid && calc_res.month_ok;
  assign out_load   = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    unique case (state)
      S_IDLE:  state_next = in_accept ? S_CALC : S_IDLE;
      S_CALC:  state_next = calc_done ? (scan_start ? S_SCAN : S_DONE) : S_CALC;
      S_SCAN:  state_next = scan_out.done ? S_DONE : S_SCAN;
      S_DONE:  state_next = out_load ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_next.pad             = '0;
    out_next.advent_day      = calc_res.advent_day;
    out_next.easter_day      = calc_res.easter_day;
    out_next.easter_month    = calc_res.easter_month;
    out_next.is_summertime   = calc_res.summer;
    // an invalid date repeats the stored holidays and never flags a change
    out_next.holiday_changed = item_valid && ((res_today != stored_today)
                             || (res_tomorrow != stored_tomorrow));
    out_next.holiday_tomorrow = item_valid ? res_tomorrow : stored_tomorrow;
    out_next.holiday_today    = item_valid ? res_today : stored_today;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      enable_mask     <= 32'd0;
      use_summer      <= 1'b0;
      stored_today    <= 5'd0;
      stored_tomorrow <= 5'd0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (hce_pkg::cfg_reg_t'(cfg_index))
          hce_pkg::REG_ENABLE_MASK: enable_mask <= cfg_data;
          hce_pkg::REG_USE_SUMMER:  use_summer  <= cfg_data[0];
          default:                  use_summer  <= use_summer;
        endcase
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
        if (item_valid) begin
          stored_today    <= res_today;
          stored_tomorrow <= res_tomorrow;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_valid <= s_tuser;
    end
    if ((state == S_CALC) && calc_done && !scan_start) begin
      res_today    <= 5'd0;
      res_tomorrow <= 5'd0;
    end
    if ((state == S_SCAN) && scan_out.done) begin
      res_today    <= scan_out.today;
      res_tomorrow <= scan_out.tomorrow;
    end
    if (out_load) begin
      out_q <= out_next;
    end
  end

  assign m_tdata = out_q;

  `HCE_ASSERT_IMPLY(a_scan_busy_state, scan_out.busy, state == S_SCAN,
    "scan runs outside scan state")
  `HCE_ASSERT_IMPLY(a_calc_done_state, calc_done, state == S_CALC,
    "date calc finished outside calc state")
  `HCE_ASSERT_NEXT(a_out_matches_stored, out_load,
    (out_q.holiday_today == stored_today) && (out_q.holiday_tomorrow == stored_tomorrow),
    "result differs from stored holidays")
  `HCE_ASSERT_NEXT(a_invalid_holds, out_load && !item_valid,
    (stored_today == $past(stored_today)) && (stored_tomorrow == $past(stored_tomorrow))
      && !out_q.holiday_changed,
    "invalid date changed holiday state")

endmodule

`default_nettype wire

// ===== bench/tb_holiday_calendar_engine_core.sv =====
// Self-checking bench for the holiday calendar engine: directed rows, random date walks.
`timescale 1ns / 100ps

module tb_holiday_calendar_engine_core;

  localparam int N_FEASTS = hce_pkg::NUM_HOLIDAYS_DEF;
  localparam int N_PLAN   = 23;
  // day-of-week keys of March, October and December
  localparam int KEY_MAR  = 2;
  localparam int KEY_OCT  = 6;
  localparam int KEY_DEC  = 4;

  typedef enum {ROW_DATE, ROW_CFG, ROW_PINNED} row_kind_t;

  typedef struct {
    hce_pkg::hol_kind_t kind;
    int                 ofs;
    int                 mon;
  } feast_t;

  typedef struct {
    row_kind_t          kind;
    logic [31:0]        mask;
    bit                 summer;
    hce_pkg::in_item_t  date;
    bit                 date_ok;
    hce_pkg::out_item_t want;
  } plan_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [31:0]                   s_tdata = '0;
  logic                          s_tuser = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [31:0]                   m_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [hce_pkg::CFG_IDX_W-1:0] cfg_index = hce_pkg::REG_ENABLE_MASK;
  logic [31:0]                   cfg_data = '0;

  // predictor state and register copies
  logic [31:0] feast_mask = '0;
  logic        dst_enabled = 1'b0;
  logic [4:0]  held_today = '0;
  logic [4:0]  held_tomorrow = '0;

  hce_pkg::out_item_t due_days[$];
  hce_pkg::out_item_t due_day;
  hce_pkg::out_item_t seen_day;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  int          walk_y = 2024;
  int          walk_m = 3;
  int          walk_d = 20;
  plan_row_t   plan[N_PLAN];

  holiday_calendar_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit is_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_start(input int m);
    case (m)
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      12:      return 334;
      default: return 0;
    endcase
  endfunction

  function automatic int month_len(input int y, input int m);
    case (m)
      2:           return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // wraps day 0 back to the year's end and a day past the end to January
  function automatic int day_of_year(input int y, input int m, input int d);
    int len;
    int o;
    len = is_leap(y) ? 366 : 365;
    o = month_start(m) + d + ((is_leap(y) && m > 2) ? 1 : 0);
    if (o < 1) o += len;
    if (o > len) o -= len;
    return o;
  endfunction

  // Sunday = 0, valid for March and later only
  function automatic int dow(input int y, input int key, input int d);
    return (y + y / 4 - y / 100 + y / 400 + key + d) % 7;
  endfunction

  function automatic feast_t feast(input hce_pkg::hol_kind_t kind, input int ofs,
                                   input int mon);
    feast_t f;
    f.kind = kind;
    f.ofs  = ofs;
    f.mon  = mon;
    return f;
  endfunction

  function automatic feast_t feast_rule(input int idx);
    case (idx)
      0:       return feast(hce_pkg::KIND_FIXED, 1, 1);
      1:       return feast(hce_pkg::KIND_FIXED, 6, 1);
      2:       return feast(hce_pkg::KIND_EASTER, -52, 0);
      3:       return feast(hce_pkg::KIND_EASTER, -48, 0);
      4:       return feast(hce_pkg::KIND_EASTER, -47, 0);
      5:       return feast(hce_pkg::KIND_EASTER, -46, 0);
      6:       return feast(hce_pkg::KIND_EASTER, -3, 0);
      7:       return feast(hce_pkg::KIND_EASTER, -2, 0);
      8:       return feast(hce_pkg::KIND_EASTER, 0, 0);
      9:       return feast(hce_pkg::KIND_EASTER, 1, 0);
      10:      return feast(hce_pkg::KIND_FIXED, 1, 5);
      11:      return feast(hce_pkg::KIND_EASTER, 39, 0);
      12:      return feast(hce_pkg::KIND_EASTER, 49, 0);
      13:      return feast(hce_pkg::KIND_EASTER, 50, 0);
      14:      return feast(hce_pkg::KIND_EASTER, 60, 0);
      15:      return feast(hce_pkg::KIND_FIXED, 8, 8);
      16:      return feast(hce_pkg::KIND_FIXED, 15, 8);
      17:      return feast(hce_pkg::KIND_FIXED, 3, 10);
      18:      return feast(hce_pkg::KIND_FIXED, 31, 10);
      19:      return feast(hce_pkg::KIND_FIXED, 1, 11);
      20:      return feast(hce_pkg::KIND_ADVENT, -32, 0);
      21:      return feast(hce_pkg::KIND_ADVENT, -21, 0);
      22:      return feast(hce_pkg::KIND_ADVENT, -14, 0);
      23:      return feast(hce_pkg::KIND_ADVENT, -7, 0);
      24:      return feast(hce_pkg::KIND_ADVENT, 0, 0);
      25:      return feast(hce_pkg::KIND_FIXED, 24, 12);
      26:      return feast(hce_pkg::KIND_FIXED, 25, 12);
      27:      return feast(hce_pkg::KIND_FIXED, 26, 12);
      28:      return feast(hce_pkg::KIND_FIXED, 31, 12);
      default: return feast(hce_pkg::KIND_FIXED, 0, 0);
    endcase
  endfunction

  function automatic hce_pkg::in_item_t pack_date(input int y, input int m, input int d,
                                                  input int h);
    hce_pkg::in_item_t it;
    it = '0;
    it.year  = 12'(y);
    it.month = 4'(m);
    it.day   = 5'(d);
    it.hour  = 5'(h);
    return it;
  endfunction

  function automatic plan_row_t mk_date(input int y, input int m, input int d, input int h,
                                        input bit ok);
    plan_row_t r;
    r.kind    = ROW_DATE;
    r.mask    = '0;
    r.summer  = 1'b0;
    r.date    = pack_date(y, m, d, h);
    r.date_ok = ok;
    r.want    = '0;
    return r;
  endfunction

  function automatic plan_row_t mk_cfg(input logic [31:0] mask, input bit summer);
    plan_row_t r;
    r = mk_date(0, 0, 0, 0, 1'b0);
    r.kind   = ROW_CFG;
    r.mask   = mask;
    r.summer = summer;
    return r;
  endfunction

  // valid date whose result is typed in
  function automatic plan_row_t mk_pinned(input int y, input int m, input int d, input int h,
                                          input int today, input int tomorrow, input bit chg,
                                          input bit summ, input int em, input int ed,
                                          input int adv);
    plan_row_t r;
    r = mk_date(y, m, d, h, 1'b1);
    r.kind = ROW_PINNED;
    r.want.holiday_today    = 5'(today);
    r.want.holiday_tomorrow = 5'(tomorrow);
    r.want.holiday_changed  = chg;
    r.want.is_summertime    = summ;
    r.want.easter_month     = 3'(em);
    r.want.easter_day       = 5'(ed);
    r.want.advent_day       = 5'(adv);
    return r;
  endfunction

  // Easter, Advent and DST from the date; holidays of today and tomorrow from the table
  task automatic predict_day(input hce_pkg::in_item_t it, input bit date_ok,
                             output hce_pkg::out_item_t res);
    int y, mo, dd, hr;
    int a, b, c, k, q, p, egz, mm, nn, d, e, em, ed, adv, ls;
    int len, tod, tom, east, advo, h, nt, nm;
    bit summer;
    feast_t f;
    y  = it.year;
    mo = it.month;
    dd = it.day;
    hr = it.hour;
    a = y % 19;
    b = y % 4;
    c = y % 7;
    k = y / 100;
    q = k / 4;
    p = (8 * k + 13) / 25;
    egz = (38 - (k - q) + p) % 30;
    mm = (53 - egz) % 30;
    nn = (4 + k - q) % 7;
    d = (19 * a + mm) % 30;
    e = (2 * b + 4 * c + 6 * d + nn) % 7;
    if (22 + d + e <= 31) begin
      em = 3;
      ed = 22 + d + e;
    end else begin
      em = 4;
      ed = d + e - 9;
      if (ed == 26) ed = 19;
      else if (ed == 25 && d == 28 && a > 10) ed = 18;
    end
    adv = 24 - dow(y, KEY_DEC, 24);

    summer = 1'b0;
    if (dst_enabled) begin
      if (mo == 3) begin
        ls = 31 - dow(y, KEY_MAR, 31);
        summer = (ls == dd) ? (hr > 3) : (ls < dd);
      end else if (mo == 10) begin
        ls = 31 - dow(y, KEY_OCT, 31);
        summer = (ls == dd) ? (hr < 3) : (ls > dd);
      end else begin
        summer = (mo > 3) && (mo < 10);
      end
    end

    res = '0;
    res.holiday_today    = held_today;
    res.holiday_tomorrow = held_tomorrow;
    if (date_ok) begin
      nt = 0;
      nm = 0;
      if (mo >= 1 && mo <= 12) begin
        len  = is_leap(y) ? 366 : 365;
        tod  = day_of_year(y, mo, dd);
        tom  = (tod + 1 > len) ? 1 : tod + 1;
        east = day_of_year(y, em, ed);
        advo = day_of_year(y, 12, adv);
        // later entries overwrite; stop once both days have a match
        for (int i = 0; i < N_FEASTS && i < 32; i++) begin
          if (!feast_mask[31 - i]) continue;
          f = feast_rule(i);
          case (f.kind)
            hce_pkg::KIND_EASTER: h = east + f.ofs;
            hce_pkg::KIND_ADVENT: h = advo + f.ofs;
            default:              h = day_of_year(y, f.mon, f.ofs);
          endcase
          if (h == tod) nt = i + 1;
          if (h == tom) nm = i + 1;
          if (nt > 0 && nm > 0) break;
        end
      end
      res.holiday_changed = (nt != held_today) || (nm != held_tomorrow);
      held_today    = 5'(nt);
      held_tomorrow = 5'(nm);
      res.holiday_today    = held_today;
      res.holiday_tomorrow = held_tomorrow;
    end
    res.is_summertime = summer;
    res.easter_month  = 3'(em);
    res.easter_day    = 5'(ed);
    res.advent_day    = 5'(adv);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_date(input hce_pkg::in_item_t it, input bit ok, input bit pinned,
                           input hce_pkg::out_item_t want);
    hce_pkg::out_item_t calc;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    s_tuser  <= ok;
    do @(posedge clk); while (!s_tready);
    predict_day(it, ok, calc);
    due_days.push_back(pinned ? want : calc);
    @(negedge clk);
  endtask

  // drain first so the block is idle, then write both registers back to back
  task automatic write_regs(input logic [31:0] mask, input bit summer);
    hce_pkg::cfg_reg_t sel;
    logic [31:0]       val;
    while (due_days.size() != 0) @(negedge clk);
    for (int r = 0; r < 2; r++) begin
      sel = (r == 0) ? hce_pkg::REG_ENABLE_MASK : hce_pkg::REG_USE_SUMMER;
      val = (r == 0) ? mask : {31'b0, summer};
      cfg_valid <= 1'b1;
      cfg_index <= sel;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      if (sel == hce_pkg::REG_ENABLE_MASK) feast_mask = val;
      else dst_enabled = val[0];
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly a day-by-day calendar walk, with jumps, invalid dates and raw noise
  task automatic draw_date(output hce_pkg::in_item_t it, output bit ok);
    int mode;
    mode = $urandom_range(99);
    if (mode < 8) begin
      it = pack_date($urandom_range(4095), $urandom_range(15), $urandom_range(31),
                     $urandom_range(31));
      ok = $urandom_range(1);
    end else begin
      if (mode < 14) begin
        walk_y = $urandom_range(1900, 2099);
        walk_m = $urandom_range(1) ? $urandom_range(2, 6) : $urandom_range(1, 12);
        walk_d = $urandom_range(1, month_len(walk_y, walk_m));
      end else if (mode >= 30) begin
        walk_d++;
        if (walk_d > month_len(walk_y, walk_m)) begin
          walk_d = 1;
          walk_m++;
          if (walk_m > 12) begin
            walk_m = 1;
            walk_y++;
          end
        end
      end
      // the remaining modes repeat the day at another hour
      it = pack_date(walk_y, walk_m, walk_d, $urandom_range(23));
      ok = ($urandom_range(19) != 0);
    end
  endtask

  task automatic run_phase(input logic [31:0] mask, input bit summer, input int idle_pct,
                           input int stall_pct, input int n, input int hold);
    hce_pkg::in_item_t it;
    bit                ok;
    write_regs(mask, summer);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold > 0) begin
      @(posedge clk);
      hold_left = hold;
      @(negedge clk);
    end
    repeat (n) begin
      draw_date(it, ok);
      send_date(it, ok, 1'b0, '0);
    end
    s_tvalid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_day = m_tdata;
      if (due_days.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
      end else begin
        due_day = due_days.pop_front();
        check_field("holiday_today", due_day.holiday_today, seen_day.holiday_today);
        check_field("holiday_tomorrow", due_day.holiday_tomorrow, seen_day.holiday_tomorrow);
        check_field("holiday_changed", due_day.holiday_changed, seen_day.holiday_changed);
        check_field("is_summertime", due_day.is_summertime, seen_day.is_summertime);
        check_field("easter_month", due_day.easter_month, seen_day.easter_month);
        check_field("easter_day", due_day.easter_day, seen_day.easter_day);
        check_field("advent_day", due_day.advent_day, seen_day.advent_day);
        check_field("pad", due_day.pad, seen_day.pad);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    plan = '{
      // registers still at reset: no holidays, no DST
      mk_pinned(2024, 6, 15, 12, 0, 0, 1'b0, 1'b0, 3, 31, 22),
      mk_pinned(2024, 0, 5, 0, 0, 0, 1'b0, 1'b0, 3, 31, 22),
      mk_cfg(32'hFFFF_FFFF, 1'b1),
      mk_pinned(2024, 1, 1, 0, 1, 0, 1'b1, 1'b0, 3, 31, 22),
      mk_pinned(2024, 12, 31, 23, 29, 1, 1'b1, 1'b0, 3, 31, 22),
      mk_date(2024, 1, 0, 5, 1'b1),
      mk_date(2023, 2, 31, 7, 1'b1),
      mk_date(2024, 3, 31, 3, 1'b1),
      mk_date(2024, 3, 31, 4, 1'b1),
      mk_date(2024, 10, 27, 2, 1'b1),
      mk_date(2024, 10, 27, 3, 1'b1),
      mk_date(1981, 4, 19, 12, 1'b1),
      mk_date(1954, 4, 18, 12, 1'b1),
      mk_date(2024, 4, 1, 10, 1'b1),
      mk_date(2023, 12, 24, 8, 1'b1),
      mk_date(2024, 7, 4, 9, 1'b0),
      mk_date(0, 15, 31, 31, 1'b1),
      mk_date(4095, 13, 0, 0, 1'b1),
      mk_date(1900, 2, 28, 0, 1'b1),
      mk_date(2099, 12, 31, 23, 1'b1),
      mk_date(4095, 12, 31, 31, 1'b0),
      mk_date(2000, 2, 29, 22, 1'b1),
      mk_date(2025, 3, 3, 0, 1'b1)
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        s_tvalid <= 1'b0;
        write_regs(plan[i].mask, plan[i].summer);
      end else begin
        send_date(plan[i].date, plan[i].date_ok, plan[i].kind == ROW_PINNED, plan[i].want);
      end
    end
    s_tvalid <= 1'b0;

    run_phase(32'hFFFF_FFFF, 1'b1, 0, 0, 300, 0);
    run_phase($urandom(), 1'b1, 88, 0, 250, 0);
    run_phase($urandom(), 1'b0, 0, 88, 250, 0);
    run_phase(32'hFFFF_FFF8, 1'b1, 18, 18, 300, 0);
    // long receiver hold-off while dates keep coming: input must back up
    run_phase(32'hFFFF_FFFF, 1'b1, 0, 0, 200, 400);
    run_phase(32'h0000_0000, 1'b0, 18, 18, 150, 0);
    run_phase($urandom(), 1'b1, 0, 0, 150, 0);

    while (due_days.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
